/* rtl/srd_pkg.sv */
// srd_pkg: shared types, codes and helper functions of the scanline RLE decoder.
// Used by srd_step and scanline_rle_decoder; depends on nothing.

package srd_pkg;

    localparam int MAX_PACKETS = 4;
    localparam int PKT_IDX_W   = 2;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PKT_CNT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DESC0   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_DESC1   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_DESC2   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_DESC3   = 3'd6;

    // decode phases
    localparam logic [2:0] PH_COUNT   = 3'd0;
    localparam logic [2:0] PH_LONG_HI = 3'd1;
    localparam logic [2:0] PH_LONG_LO = 3'd2;
    localparam logic [2:0] PH_RUN     = 3'd3;
    localparam logic [2:0] PH_LIT     = 3'd4;
    localparam logic [2:0] PH_RAW     = 3'd5;

    // packet types
    localparam logic [1:0] TYPE_RAW   = 2'd0;
    localparam logic [1:0] TYPE_PURE  = 2'd1;
    localparam logic [1:0] TYPE_MIXED = 2'd2;
    localparam logic [1:0] TYPE_BAD   = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_OVERRUN    = 2'd1;
    localparam logic [1:0] ERR_BAD_PACKET = 2'd2;

    localparam logic [7:0]  LONG_MARK  = 8'd128;
    localparam logic [15:0] SHORT_BIAS = 16'd127;
    localparam logic [5:0]  MASK_BITS  = 6'h0F;

    typedef struct packed {
        logic [15:0]                  width;
        logic [15:0]                  height;
        logic [2:0]                   pkt_count;
        logic [MAX_PACKETS-1:0][5:0]  desc;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        width:     16'd1,
        height:    16'd1,
        pkt_count: 3'd1,
        desc:      {6'd0, 6'd0, 6'd0, 6'd39}
    };

    typedef struct packed {
        logic [2:0]           phase;
        logic [15:0]          row;
        logic [15:0]          pixel;
        logic [PKT_IDX_W-1:0] pkt_idx;
        logic [15:0]          run_rem;
        logic [15:0]          run_start;
        logic [1:0]           slot;
        logic [7:0]           long_hi;
    } state_t;

    typedef struct packed {
        logic [15:0] row;
        logic [15:0] start_pixel;
        logic [15:0] run_length;
        logic [1:0]  channel;
        logic [7:0]  value;
        logic [1:0]  error;
        logic        image_done;
    } result_t;

    function automatic logic [15:0] eff_width(cfg_t c);
        return (c.width == 16'd0) ? 16'd1 : c.width;
    endfunction

    function automatic logic [15:0] eff_height(cfg_t c);
        return (c.height == 16'd0) ? 16'd1 : c.height;
    endfunction

    function automatic logic [2:0] eff_packets(cfg_t c);
        logic [2:0] n;
        n = c.pkt_count;
        if (n == 3'd0)
            n = 3'd1;
        if (n > 3'(MAX_PACKETS))
            n = 3'(MAX_PACKETS);
        return n;
    endfunction

    // k-th enabled channel of the mask, red first
    function automatic logic [1:0] nth_channel(logic [3:0] mask, logic [1:0] k);
        logic [2:0] seen;
        logic [1:0] ch;
        logic       found;
        seen  = 3'd0;
        ch    = 2'd0;
        found = 1'b0;
        for (int b = 0; b < 4; b++)
        begin
            if (mask[b] && !found)
            begin
                if (seen == {1'b0, k})
                begin
                    ch    = 2'(b);
                    found = 1'b1;
                end
                seen = seen + 3'd1;
            end
        end
        return ch;
    endfunction

    function automatic state_t enter_packet(state_t s, cfg_t c);
        state_t r;
        r         = s;
        r.slot    = 2'd0;
        r.run_rem = 16'd0;
        r.phase   = (c.desc[s.pkt_idx][5:4] == TYPE_RAW) ? PH_RAW : PH_COUNT;
        return r;
    endfunction

    function automatic state_t restart_state(cfg_t c);
        state_t s;
        s           = '0;
        s.row       = eff_height(c) - 16'd1;
        s.pixel     = 16'd0;
        s.pkt_idx   = '0;
        s.run_start = 16'd0;
        s.long_hi   = 8'd0;
        return enter_packet(s, c);
    endfunction

    // true when finishing the current packet completes the top row
    function automatic logic finish_done(state_t s, cfg_t c);
        logic [2:0] npk;
        npk = {1'b0, s.pkt_idx} + 3'd1;
        return (npk >= eff_packets(c)) && (s.row == 16'd0);
    endfunction

    function automatic state_t finish_packet(state_t s, cfg_t c);
        state_t     r;
        logic [2:0] npk;
        r   = s;
        npk = {1'b0, s.pkt_idx} + 3'd1;
        if (npk >= eff_packets(c))
        begin
            r.pkt_idx = '0;
            r.pixel   = 16'd0;
            if (s.row == 16'd0)
                return restart_state(c);
            r.row = s.row - 16'd1;
        end
        else
        begin
            r.pkt_idx = npk[PKT_IDX_W-1:0];
        end
        return enter_packet(r, c);
    endfunction

endpackage

/* rtl/scanline_rle_decoder.sv */
// scanline_rle_decoder: top level, configuration registers, decode state and result register.
// Depends on srd_pkg and srd_step.

// One encoded body byte is taken per cycle, and each colour byte yields one fill result in the
// next cycle through a single output register. The decode state updates in the cycle the byte
// is transferred (one pass through srd_step), so the input accepts a byte every cycle as long as
// the output register is empty or being drained in the same cycle. Count bytes and long-count
// bytes produce no result unless they raise an error. Any write to addresses 0 to 6 restarts
// decoding at the first packet of the bottom row; write registers only while no byte is in flight.

module scanline_rle_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_we,
    input  logic [srd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [srd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // encoded byte stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [7:0] data_byte
    // fill results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [63:0]                    m_tdata,  // [15:0] row, [31:16] start_pixel,
                                                     // [47:32] run_length, [49:48] channel,
                                                     // [57:50] value, [63:58] zero
    output logic [1:0]                     m_tuser,  // [1:0] error
    output logic                           m_tlast   // image_done
);

    srd_pkg::cfg_t    cfg_reg;
    srd_pkg::cfg_t    cfg_next;
    logic             cfg_hit;
    srd_pkg::state_t  state_reg;
    srd_pkg::state_t  step_next;
    srd_pkg::result_t step_res;
    logic             step_valid;
    srd_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             in_xfer;

    always_comb
    begin
        cfg_next = cfg_reg;
        cfg_hit  = cfg_we;
        case (cfg_addr)
            srd_pkg::CFG_WIDTH:   cfg_next.width     = cfg_wdata;
            srd_pkg::CFG_HEIGHT:  cfg_next.height    = cfg_wdata;
            srd_pkg::CFG_PKT_CNT: cfg_next.pkt_count = cfg_wdata[2:0];
            srd_pkg::CFG_DESC0:   cfg_next.desc[0]   = cfg_wdata[5:0];
            srd_pkg::CFG_DESC1:   cfg_next.desc[1]   = cfg_wdata[5:0];
            srd_pkg::CFG_DESC2:   cfg_next.desc[2]   = cfg_wdata[5:0];
            srd_pkg::CFG_DESC3:   cfg_next.desc[3]   = cfg_wdata[5:0];
            default:              cfg_hit            = 1'b0;
        endcase
    end

    srd_step u_step (
        .cfg       (cfg_reg),
        .st        (state_reg),
        .data_byte (s_tdata),
        .st_next   (step_next),
        .res       (step_res),
        .res_valid (step_valid)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= srd_pkg::CFG_RESET;
            state_reg <= srd_pkg::restart_state(srd_pkg::CFG_RESET);
        end
        else if (cfg_hit)
        begin
            cfg_reg   <= cfg_next;
            state_reg <= srd_pkg::restart_state(cfg_next);
        end
        else if (in_xfer)
        begin
            state_reg <= step_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= step_valid;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && step_valid)
            out_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.value, out_reg.channel, out_reg.run_length,
                       out_reg.start_pixel, out_reg.row};
    assign m_tuser  = out_reg.error;
    assign m_tlast  = out_reg.image_done;

endmodule

/* rtl/srd_step.sv */
// srd_step: next-state and result logic for one encoded byte.
// Purely combinational; depends on srd_pkg.

module srd_step (
    input  srd_pkg::cfg_t    cfg,
    input  srd_pkg::state_t  st,
    input  logic [7:0]       data_byte,
    output srd_pkg::state_t  st_next,
    output srd_pkg::result_t res,
    output logic             res_valid
);

    logic [5:0]  desc;
    logic [3:0]  mask;
    logic [1:0]  ptype;
    logic [2:0]  ncol;
    logic [15:0] w;
    logic [15:0] rem;
    logic [15:0] run_n;
    logic [16:0] run_end;
    logic [16:0] lit_end;
    logic [2:0]  slot_inc;
    logic        do_fail;
    logic [1:0]  fail_code;
    logic        done;

    assign desc     = cfg.desc[st.pkt_idx];
    assign mask     = 4'(desc & srd_pkg::MASK_BITS);
    assign ptype    = desc[5:4];
    assign ncol     = {2'b0, mask[0]} + {2'b0, mask[1]} + {2'b0, mask[2]} + {2'b0, mask[3]};
    assign w        = srd_pkg::eff_width(cfg);
    assign rem      = w - st.pixel;
    assign slot_inc = {1'b0, st.slot} + 3'd1;

    // run length for whichever count form this byte completes
    always_comb
    begin
        if (st.phase == srd_pkg::PH_LONG_LO)
            run_n = {st.long_hi, data_byte};
        else if (ptype == srd_pkg::TYPE_PURE)
            run_n = ({8'd0, data_byte} > rem) ? rem : {8'd0, data_byte};
        else
            run_n = {8'd0, data_byte} - srd_pkg::SHORT_BIAS;
    end

    assign run_end = {1'b0, st.pixel} + {1'b0, run_n};
    assign lit_end = {1'b0, st.pixel} + {9'd0, data_byte} + 17'd1;

    always_comb
    begin
        st_next   = st;
        res       = '0;
        res_valid = 1'b0;
        do_fail   = 1'b0;
        fail_code = srd_pkg::ERR_NONE;
        done      = 1'b0;

        if (ptype == srd_pkg::TYPE_BAD || mask == 4'd0)
        begin
            do_fail   = 1'b1;
            fail_code = srd_pkg::ERR_BAD_PACKET;
        end
        else
        begin
            case (st.phase)
                srd_pkg::PH_COUNT, srd_pkg::PH_LONG_LO:
                begin
                    if (st.phase == srd_pkg::PH_COUNT && ptype != srd_pkg::TYPE_PURE
                        && data_byte == srd_pkg::LONG_MARK)
                    begin
                        st_next.phase = srd_pkg::PH_LONG_HI;
                    end
                    else if (st.phase == srd_pkg::PH_COUNT && ptype != srd_pkg::TYPE_PURE
                             && data_byte < srd_pkg::LONG_MARK)
                    begin
                        // literal group
                        if (lit_end > {1'b0, w})
                        begin
                            do_fail   = 1'b1;
                            fail_code = srd_pkg::ERR_OVERRUN;
                        end
                        else
                        begin
                            st_next.run_rem = {8'd0, data_byte} + 16'd1;
                            st_next.slot    = 2'd0;
                            st_next.phase   = srd_pkg::PH_LIT;
                        end
                    end
                    else if (run_end > {1'b0, w})
                    begin
                        do_fail   = 1'b1;
                        fail_code = srd_pkg::ERR_OVERRUN;
                    end
                    else
                    begin
                        st_next.run_start = st.pixel;
                        st_next.run_rem   = run_n;
                        st_next.pixel     = run_end[15:0];
                        st_next.slot      = 2'd0;
                        st_next.phase     = srd_pkg::PH_RUN;
                    end
                end
                srd_pkg::PH_LONG_HI:
                begin
                    st_next.long_hi = data_byte;
                    st_next.phase   = srd_pkg::PH_LONG_LO;
                end
                srd_pkg::PH_RUN:
                begin
                    res_valid       = 1'b1;
                    res.row         = st.row;
                    res.start_pixel = st.run_start;
                    res.run_length  = st.run_rem;
                    res.channel     = srd_pkg::nth_channel(mask, st.slot);
                    res.value       = data_byte;
                    st_next.slot    = slot_inc[1:0];
                    if (slot_inc >= ncol)
                    begin
                        st_next.slot = 2'd0;
                        if (st.pixel >= w)
                        begin
                            done    = srd_pkg::finish_done(st_next, cfg);
                            st_next = srd_pkg::finish_packet(st_next, cfg);
                        end
                        else
                        begin
                            st_next.phase = srd_pkg::PH_COUNT;
                        end
                    end
                end
                srd_pkg::PH_LIT, srd_pkg::PH_RAW:
                begin
                    res_valid       = 1'b1;
                    res.row         = st.row;
                    res.start_pixel = st.pixel;
                    res.run_length  = 16'd1;
                    res.channel     = srd_pkg::nth_channel(mask, st.slot);
                    res.value       = data_byte;
                    st_next.slot    = slot_inc[1:0];
                    if (slot_inc >= ncol)
                    begin
                        st_next.slot  = 2'd0;
                        st_next.pixel = st.pixel + 16'd1;
                        if (st.phase == srd_pkg::PH_LIT)
                        begin
                            if (st.run_rem != 16'd0)
                                st_next.run_rem = st.run_rem - 16'd1;
                            if (st_next.run_rem == 16'd0)
                            begin
                                if (st_next.pixel >= w)
                                begin
                                    done    = srd_pkg::finish_done(st_next, cfg);
                                    st_next = srd_pkg::finish_packet(st_next, cfg);
                                end
                                else
                                begin
                                    st_next.phase = srd_pkg::PH_COUNT;
                                end
                            end
                        end
                        else if (st_next.pixel >= w)
                        begin
                            done    = srd_pkg::finish_done(st_next, cfg);
                            st_next = srd_pkg::finish_packet(st_next, cfg);
                        end
                    end
                end
                default:
                begin
                    do_fail   = 1'b1;
                    fail_code = srd_pkg::ERR_BAD_PACKET;
                end
            endcase
        end

        res.image_done = done;

        if (do_fail)
        begin
            res_valid       = 1'b1;
            res             = '0;
            res.row         = st.row;
            res.start_pixel = st.pixel;
            res.error       = fail_code;
            st_next         = srd_pkg::restart_state(cfg);
        end
    end

endmodule
